// ----- sv/gpe_pkg.sv -----
package gpe_pkg;

    // Parser phases
    typedef enum logic [3:0] {
        PH_HEADER    = 4'd0,
        PH_GLOBAL    = 4'd1,
        PH_SCAN      = 4'd2,
        PH_EXT_LABEL = 4'd3,
        PH_SUB_SIZE  = 4'd4,
        PH_SUB_DATA  = 4'd5,
        PH_DESC      = 4'd6,
        PH_LOCAL     = 4'd7,
        PH_DONE      = 4'd8
    } t_phase;

    // Final status codes
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_SHORT        = 3'd1,
        ST_SIGNATURE    = 3'd2,
        ST_GLOBAL_TRUNC = 3'd3,
        ST_NO_TABLE     = 3'd4
    } t_status;

    // Bytes and positions of the file format
    localparam logic [7:0] SIG_G       = 8'h47;
    localparam logic [7:0] SIG_I       = 8'h49;
    localparam logic [7:0] SIG_F       = 8'h46;
    localparam logic [7:0] BYTE_EXT    = 8'h21;
    localparam logic [7:0] BYTE_DESC   = 8'h2C;
    localparam logic [7:0] BYTE_TRAIL  = 8'h3B;
    localparam logic [3:0] HDR_FLAGS   = 4'd10;
    localparam logic [3:0] HDR_LAST    = 4'd12;
    localparam logic [3:0] DESC_PACKED = 4'd8;
    localparam int         TBL_BIT     = 7;

    // Output word layout
    localparam int TDATA_W = 40;

    // One result word from the parser
    typedef struct packed {
        logic       entry_valid;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       final_res;
        t_status    status;
    } t_result;

endpackage

// ----- sv/gpe_parser.sv -----
module gpe_parser
    import gpe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,        // consume the presented byte
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_has_result,
    output t_result    o_result
);

    t_phase     r_phase,  n_phase;
    logic [3:0] r_hdr_cnt, n_hdr_cnt;
    logic       r_sig_ok, n_sig_ok;
    logic [7:0] r_flags,  n_flags;
    logic [3:0] r_desc_cnt, n_desc_cnt;
    logic [8:0] r_ent_cnt, n_ent_cnt;
    logic [1:0] r_comp,   n_comp;
    logic [7:0] r_red,    n_red;
    logic [7:0] r_green,  n_green;
    logic [7:0] r_skip,   n_skip;

    logic       fin;
    logic       ent;
    t_status    st;
    logic [8:0] tbl_size;
    logic [8:0] ent_inc;
    t_status    tbl_err;

    assign tbl_size = 9'd2 << r_flags[2:0];
    assign ent_inc  = r_ent_cnt + 9'd1;
    assign tbl_err  = (r_phase == PH_GLOBAL) ? ST_GLOBAL_TRUNC : ST_NO_TABLE;

    // Next-state logic
    always_comb begin
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_sig_ok   = r_sig_ok;
        n_flags    = r_flags;
        n_desc_cnt = r_desc_cnt;
        n_ent_cnt  = r_ent_cnt;
        n_comp     = r_comp;
        n_red      = r_red;
        n_green    = r_green;
        n_skip     = r_skip;
        fin        = 1'b0;
        ent        = 1'b0;
        st         = ST_OK;
        case (r_phase)
            PH_HEADER: begin
                if (r_hdr_cnt == 4'd0 && i_byte != SIG_G) n_sig_ok = 1'b0;
                if (r_hdr_cnt == 4'd1 && i_byte != SIG_I) n_sig_ok = 1'b0;
                if (r_hdr_cnt == 4'd2 && i_byte != SIG_F) n_sig_ok = 1'b0;
                if (r_hdr_cnt == HDR_FLAGS) n_flags = i_byte;
                if (r_hdr_cnt >= HDR_LAST) begin
                    if (!r_sig_ok) begin
                        fin = 1'b1;
                        st  = ST_SIGNATURE;
                    end else if (r_flags[TBL_BIT]) begin
                        if (i_last) begin
                            fin = 1'b1;
                            st  = ST_GLOBAL_TRUNC;
                        end else begin
                            n_phase   = PH_GLOBAL;
                            n_ent_cnt = '0;
                            n_comp    = '0;
                        end
                    end else if (i_last) begin
                        fin = 1'b1;
                        st  = ST_NO_TABLE;
                    end else begin
                        n_phase = PH_SCAN;
                    end
                end else begin
                    n_hdr_cnt = r_hdr_cnt + 4'd1;
                    if (i_last) begin
                        fin = 1'b1;
                        st  = ST_SHORT;
                    end
                end
            end
            PH_GLOBAL, PH_LOCAL: begin
                if (r_comp == 2'd0) begin
                    n_red  = i_byte;
                    n_comp = 2'd1;
                    if (i_last) begin
                        fin = 1'b1;
                        st  = tbl_err;
                    end
                end else if (r_comp == 2'd1) begin
                    n_green = i_byte;
                    n_comp  = 2'd2;
                    if (i_last) begin
                        fin = 1'b1;
                        st  = tbl_err;
                    end
                end else begin
                    ent       = 1'b1;
                    n_ent_cnt = ent_inc;
                    n_comp    = '0;
                    if (ent_inc >= tbl_size) begin
                        fin = 1'b1;
                        st  = ST_OK;
                    end else if (i_last) begin
                        fin = 1'b1;
                        st  = tbl_err;
                    end
                end
            end
            PH_SCAN: begin
                if (i_last) begin
                    fin = 1'b1;
                    st  = ST_NO_TABLE;
                end else if (i_byte == BYTE_EXT) begin
                    n_phase = PH_EXT_LABEL;
                end else if (i_byte == BYTE_DESC) begin
                    n_phase    = PH_DESC;
                    n_desc_cnt = '0;
                end else if (i_byte == BYTE_TRAIL) begin
                    fin = 1'b1;
                    st  = ST_NO_TABLE;
                end
            end
            PH_EXT_LABEL: begin
                if (i_last) begin
                    fin = 1'b1;
                    st  = ST_NO_TABLE;
                end else begin
                    n_phase = PH_SUB_SIZE;
                end
            end
            PH_SUB_SIZE: begin
                if (i_last) begin
                    fin = 1'b1;
                    st  = ST_NO_TABLE;
                end else if (i_byte == 8'd0) begin
                    n_phase = PH_SCAN;
                end else begin
                    n_skip  = i_byte;
                    n_phase = PH_SUB_DATA;
                end
            end
            PH_SUB_DATA: begin
                if (i_last) begin
                    fin = 1'b1;
                    st  = ST_NO_TABLE;
                end else begin
                    n_skip = r_skip - 8'd1;
                    if (r_skip == 8'd1) n_phase = PH_SUB_SIZE;
                end
            end
            PH_DESC: begin
                if (r_desc_cnt >= DESC_PACKED) begin
                    n_flags = i_byte;
                    if (!i_byte[TBL_BIT] || i_last) begin
                        fin = 1'b1;
                        st  = ST_NO_TABLE;
                    end else begin
                        n_phase   = PH_LOCAL;
                        n_ent_cnt = '0;
                        n_comp    = '0;
                    end
                end else begin
                    n_desc_cnt = r_desc_cnt + 4'd1;
                    if (i_last) begin
                        fin = 1'b1;
                        st  = ST_NO_TABLE;
                    end
                end
            end
            default: begin
            end
        endcase
        if (fin) n_phase = PH_DONE;
        // last byte re-arms everything
        if (i_last) begin
            n_phase    = PH_HEADER;
            n_hdr_cnt  = '0;
            n_sig_ok   = 1'b1;
            n_flags    = '0;
            n_desc_cnt = '0;
            n_ent_cnt  = '0;
            n_comp     = '0;
            n_red      = '0;
            n_green    = '0;
            n_skip     = '0;
        end
    end

    // Result word
    always_comb begin
        o_has_result         = ent | fin;
        o_result.entry_valid = ent;
        o_result.entry_index = ent ? r_ent_cnt[7:0] : 8'd0;
        o_result.red         = ent ? r_red : 8'd0;
        o_result.green       = ent ? r_green : 8'd0;
        o_result.blue        = ent ? i_byte : 8'd0;
        o_result.final_res   = fin;
        o_result.status      = fin ? st : ST_OK;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_cnt  <= '0;
            r_sig_ok   <= 1'b1;
            r_flags    <= '0;
            r_desc_cnt <= '0;
            r_ent_cnt  <= '0;
            r_comp     <= '0;
            r_red      <= '0;
            r_green    <= '0;
            r_skip     <= '0;
        end else if (i_adv) begin
            r_phase    <= n_phase;
            r_hdr_cnt  <= n_hdr_cnt;
            r_sig_ok   <= n_sig_ok;
            r_flags    <= n_flags;
            r_desc_cnt <= n_desc_cnt;
            r_ent_cnt  <= n_ent_cnt;
            r_comp     <= n_comp;
            r_red      <= n_red;
            r_green    <= n_green;
            r_skip     <= n_skip;
        end
    end

endmodule

// ----- sv/gif_palette_extractor_core.sv -----
// Channel   | Dir | Word contents
// ----------+-----+----------------------------------------------------------
// s_axis    | in  | tdata: data_byte[7:0]; tlast: last_byte
// m_axis    | out | tdata: entry_index, red, green, blue, status; tlast:
//           |     |   final_res; tuser: entry_valid
//
// One byte per cycle sustained while the output register is not stalled; a taken
// byte waits in the input register, and its parser result is then loaded into
// the output register.
// Bytes that cause no result just update the parser state.
// i_rst_n is synchronous, active low, and returns the parser to the header.
// A stalled output register holds its word; the input register then stalls
// only when it holds a byte that has a result to deliver.
module gif_palette_extractor_core
    import gpe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,   // [7:0] data_byte
    input  logic               i_s_axis_tlast,   // last_byte
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [TDATA_W-1:0] o_m_axis_tdata,   // [7:0] entry_index, [15:8] red,
                                                 // [23:16] green, [31:24] blue,
                                                 // [34:32] status, rest zero
    output logic               o_m_axis_tlast,   // final_res
    output logic               o_m_axis_tuser    // entry_valid
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;

    logic       has_result;
    t_result    result;
    logic       out_free;
    logic       adv;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign adv             = r_in_valid && (!has_result || out_free);
    assign o_s_axis_tready = !r_in_valid || adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    gpe_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_byte       (r_in_byte),
        .i_last       (r_in_last),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= adv && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && adv && has_result) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out.status, r_out.blue, r_out.green,
                              r_out.red, r_out.entry_index};
    assign o_m_axis_tlast  = r_out.final_res;
    assign o_m_axis_tuser  = r_out.entry_valid;

    // A word without an entry is always a final status
    a_status_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.entry_valid |-> r_out.final_res)
        else $error("status-only word without final flag");

    // A non-final word carries OK status
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.final_res |-> r_out.status == ST_OK)
        else $error("status set on non-final word");

    // A held byte with a result must land in the output register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && has_result |=> r_out_valid)
        else $error("result lost");

endmodule
